// ===== rtl/core/prf_pkg.sv =====
package prf_pkg;

    // Fixed field widths of the registers and results.
    localparam int STRENGTH_W = 17;
    localparam int CUTOFF_W   = 22;
    localparam int FORCE_W    = 32;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    // Reset values of the configuration registers.
    localparam logic [STRENGTH_W-1:0] STRENGTH_RST = 17'd25600;
    localparam logic [CUTOFF_W-1:0]   CUTOFF_RST   = 22'd89600;
    localparam logic                  MODE_RST     = 1'b1;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_STRENGTH = 2'd0,
        REG_CUTOFF   = 2'd1,
        REG_MODE     = 2'd2,
        REG_NONE     = 2'd3
    } reg_index_t;

    // Flags that ride along with an item through the divider.
    typedef struct packed {
        logic applied;
        logic neg_x;
        logic neg_y;
    } item_flags_t;

endpackage

// ===== rtl/core/prf_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a side payload.
module prf_isqrt #(
    parameter int SW     = 50,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SW-1:0]     value,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [SW/2-1:0]   root,
    output logic [SIDE_W-1:0] side_out
);

    localparam int DW = SW / 2;
    localparam int XW = SW + 2;

    logic              cur_valid [0:DW-1];
    logic [SW-1:0]     cur_value [0:DW-1];
    logic [DW-1:0]     cur_root  [0:DW-1];
    logic [SW-1:0]     cur_sq    [0:DW-1];
    logic [SIDE_W-1:0] cur_side  [0:DW-1];

    logic              valid_reg [1:DW];
    logic [SW-1:0]     value_reg [1:DW];
    logic [DW-1:0]     root_reg  [1:DW];
    logic [SW-1:0]     sq_reg    [1:DW];
    logic [SIDE_W-1:0] side_reg  [1:DW];

    genvar i;
    generate
        for (i = 0; i < DW; i++)
        begin : g_stage
            localparam int K = DW - 1 - i;
            logic [XW-1:0] cand;
            logic          take;

            if (i == 0)
            begin : g_first
                assign cur_valid[0] = in_valid;
                assign cur_value[0] = value;
                assign cur_root[0]  = '0;
                assign cur_sq[0]    = '0;
                assign cur_side[0]  = side_in;
            end
            else
            begin : g_next
                assign cur_valid[i] = valid_reg[i];
                assign cur_value[i] = value_reg[i];
                assign cur_root[i]  = root_reg[i];
                assign cur_sq[i]    = sq_reg[i];
                assign cur_side[i]  = side_reg[i];
            end

            // (root + 2^K)^2 = root^2 + root*2^(K+1) + 2^(2K).
            assign cand = XW'(cur_sq[i]) + (XW'(cur_root[i]) << (K + 1))
                        + (XW'(1) << (2 * K));
            assign take = (cand <= XW'(cur_value[i]));

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[i+1] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[i+1] <= cur_valid[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    value_reg[i+1] <= cur_value[i];
                    side_reg[i+1]  <= cur_side[i];
                    root_reg[i+1]  <= take ? (cur_root[i] | (DW'(1) << K)) : cur_root[i];
                    sq_reg[i+1]    <= take ? SW'(cand) : cur_sq[i];
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[DW];
    assign root      = root_reg[DW];
    assign side_out  = side_reg[DW];

endmodule

// ===== rtl/core/prf_divider.sv =====
// Pipelined restoring divider for two numerators over one denominator.
// The first stage flags quotients of 2^32 or more; then one quotient bit per stage.
module prf_divider
    import prf_pkg::*;
#(
    parameter int NW  = 80,
    parameter int DNW = 72
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [NW-1:0]      numx,
    input  logic [NW-1:0]      numy,
    input  logic [DNW-1:0]     den,
    input  item_flags_t        flags_in,
    output logic               out_valid,
    output logic [FORCE_W-1:0] qx,
    output logic [FORCE_W-1:0] qy,
    output logic               ovfx,
    output logic               ovfy,
    output item_flags_t        flags_out
);

    localparam int QW = FORCE_W;
    localparam int CW = (NW > DNW + QW) ? NW : DNW + QW;

    logic               valid_reg [0:QW];
    logic [DNW-1:0]     den_reg   [0:QW];
    logic [DNW-1:0]     rx_reg    [0:QW];
    logic [DNW-1:0]     ry_reg    [0:QW];
    logic [QW-1:0]      lx_reg    [0:QW];
    logic [QW-1:0]      ly_reg    [0:QW];
    logic [QW-1:0]      qx_reg    [0:QW];
    logic [QW-1:0]      qy_reg    [0:QW];
    logic               ovfx_reg  [0:QW];
    logic               ovfy_reg  [0:QW];
    item_flags_t        flags_reg [0:QW];

    logic [CW-1:0] den_top;
    assign den_top = CW'(den) << QW;

    // Overflow check and the initial partial remainder.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0]   <= den;
            ovfx_reg[0]  <= (CW'(numx) >= den_top);
            ovfy_reg[0]  <= (CW'(numy) >= den_top);
            rx_reg[0]    <= DNW'(numx >> QW);
            ry_reg[0]    <= DNW'(numy >> QW);
            lx_reg[0]    <= numx[QW-1:0];
            ly_reg[0]    <= numy[QW-1:0];
            qx_reg[0]    <= '0;
            qy_reg[0]    <= '0;
            flags_reg[0] <= flags_in;
        end
    end

    genvar i;
    generate
        for (i = 0; i < QW; i++)
        begin : g_stage
            localparam int B = QW - 1 - i;
            logic [DNW:0] tx;
            logic [DNW:0] ty;
            logic         gex;
            logic         gey;

            assign tx  = {rx_reg[i], lx_reg[i][B]};
            assign ty  = {ry_reg[i], ly_reg[i][B]};
            assign gex = (tx >= {1'b0, den_reg[i]});
            assign gey = (ty >= {1'b0, den_reg[i]});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[i+1] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[i+1] <= valid_reg[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[i+1]   <= den_reg[i];
                    rx_reg[i+1]    <= gex ? DNW'(tx - {1'b0, den_reg[i]}) : DNW'(tx);
                    ry_reg[i+1]    <= gey ? DNW'(ty - {1'b0, den_reg[i]}) : DNW'(ty);
                    lx_reg[i+1]    <= lx_reg[i];
                    ly_reg[i+1]    <= ly_reg[i];
                    qx_reg[i+1]    <= {qx_reg[i][QW-2:0], gex};
                    qy_reg[i+1]    <= {qy_reg[i][QW-2:0], gey};
                    ovfx_reg[i+1]  <= ovfx_reg[i];
                    ovfy_reg[i+1]  <= ovfy_reg[i];
                    flags_reg[i+1] <= flags_reg[i];
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[QW];
    assign qx        = qx_reg[QW];
    assign qy        = qy_reg[QW];
    assign ovfx      = ovfx_reg[QW];
    assign ovfy      = ovfy_reg[QW];
    assign flags_out = flags_reg[QW];

endmodule

// ===== rtl/core/pairwise_repulsion_force_core.sv =====
// Pairwise repulsion force between two layout nodes.
// Input stream: s_tdata carries first_x, first_y, second_x, second_y, each a
// signed position of POS_WIDTH bits with POS_FRAC_BITS fraction bits.
// Output stream: m_tdata carries force_x and force_y (signed Q16.16), and
// m_tuser carries applied (bit 0) and saturated (bit 1).
// The APB port sets the strength E, the cutoff R and the falloff mode; write
// it only while no pair is in flight.
// Throughput is one pair per cycle unless the output stalls. The input transfer
// reaches the output register through POS_WIDTH + 41 register stages: three
// setup stages, one square root stage per result bit (POS_WIDTH + 1), three
// numerator and denominator stages, a 33-stage divider and the output register.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline freezes and s_tready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults.
module pairwise_repulsion_force_core
    import prf_pkg::*;
#(
    parameter int POS_WIDTH     = 24,
    parameter int POS_FRAC_BITS = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [ADDR_W-1:0]                      paddr,
    input  logic [DATA_W-1:0]                      pwdata,
    output logic [DATA_W-1:0]                      prdata,
    output logic                                   pready,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // first_x, first_y, second_x, second_y from the lowest bit up.
    input  logic [((4*POS_WIDTH+7)/8)*8-1:0]       s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // force_x, force_y from the lowest bit up.
    output logic [2*FORCE_W-1:0]                   m_tdata,
    // applied, saturated from the lowest bit up.
    output logic [1:0]                             m_tuser
);

    localparam int P    = POS_WIDTH;
    localparam int F    = POS_FRAC_BITS;
    localparam int AW   = P + 1;
    localparam int SW   = 2 * AW;
    localparam int DW   = AW;
    localparam int AEW  = AW + STRENGTH_W;
    localparam int DFW  = CUTOFF_W + F;
    localparam int NW   = AEW + DFW + 8;
    localparam int DNW  = SW + CUTOFF_W;
    localparam int CMPW = (SW + 16 > 2 * CUTOFF_W + 2 * F) ? SW + 16 : 2 * CUTOFF_W + 2 * F;
    localparam int XW   = (DFW > DW + 8) ? DFW : DW + 8;
    localparam int H    = AEW / 2;
    localparam int SH   = SW / 2;
    localparam int SQ_SIDE = 3 + 2 * AEW + SW;

    // Configuration registers.
    logic [STRENGTH_W-1:0] strength_reg;
    logic [CUTOFF_W-1:0]   cutoff_reg;
    logic                  mode_reg;
    reg_index_t            cfg_index;
    logic                  cfg_write;

    assign pready    = 1'b1;
    assign cfg_index = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg <= STRENGTH_RST;
            cutoff_reg   <= CUTOFF_RST;
            mode_reg     <= MODE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_STRENGTH: strength_reg <= pwdata[STRENGTH_W-1:0];
                REG_CUTOFF:   cutoff_reg   <= pwdata[CUTOFF_W-1:0];
                REG_MODE:     mode_reg     <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_STRENGTH: prdata = DATA_W'(strength_reg);
            REG_CUTOFF:   prdata = DATA_W'(cutoff_reg);
            REG_MODE:     prdata = DATA_W'(mode_reg);
            default:      prdata = '0;
        endcase
    end

    // Whole-pipeline advance: stop only when a result waits and is not taken.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Stage A: offsets and their magnitudes.
    logic signed [AW-1:0] dx;
    logic signed [AW-1:0] dy;
    logic signed [P-1:0]  fx;
    logic signed [P-1:0]  fy;
    logic signed [P-1:0]  sx;
    logic signed [P-1:0]  sy;

    assign fx = s_tdata[P-1:0];
    assign fy = s_tdata[2*P-1:P];
    assign sx = s_tdata[3*P-1:2*P];
    assign sy = s_tdata[4*P-1:3*P];
    assign dx = AW'(fx) - AW'(sx);
    assign dy = AW'(fy) - AW'(sy);

    logic          v_a_reg;
    logic [AW-1:0] a_a_reg;
    logic [AW-1:0] b_a_reg;
    logic          nx_a_reg;
    logic          ny_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
        end
        else if (en)
        begin
            v_a_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_a_reg  <= dx[AW-1] ? AW'(-dx) : AW'(dx);
            b_a_reg  <= dy[AW-1] ? AW'(-dy) : AW'(dy);
            nx_a_reg <= dx[AW-1];
            ny_a_reg <= dy[AW-1];
        end
    end

    // Stage B: squares, strength products and the squared cutoff.
    logic                  v_b_reg;
    logic [SW-1:0]         aa_b_reg;
    logic [SW-1:0]         bb_b_reg;
    logic [AEW-1:0]        ae_b_reg;
    logic [AEW-1:0]        be_b_reg;
    logic [2*CUTOFF_W-1:0] rr_b_reg;
    logic                  nx_b_reg;
    logic                  ny_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_b_reg <= 1'b0;
        end
        else if (en)
        begin
            v_b_reg <= v_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aa_b_reg <= SW'(a_a_reg) * SW'(a_a_reg);
            bb_b_reg <= SW'(b_a_reg) * SW'(b_a_reg);
            ae_b_reg <= AEW'(a_a_reg) * AEW'(strength_reg);
            be_b_reg <= AEW'(b_a_reg) * AEW'(strength_reg);
            rr_b_reg <= (2*CUTOFF_W)'(cutoff_reg) * (2*CUTOFF_W)'(cutoff_reg);
            nx_b_reg <= nx_a_reg;
            ny_b_reg <= ny_a_reg;
        end
    end

    // Stage C: squared distance and the interaction test.
    logic [SW-1:0]   s_sum;
    logic            in_range;
    assign s_sum    = aa_b_reg + bb_b_reg;
    assign in_range = (CMPW'(s_sum) << 16) < (CMPW'(rr_b_reg) << (2 * F));

    logic           v_c_reg;
    logic [SW-1:0]  s_c_reg;
    logic [AEW-1:0] ae_c_reg;
    logic [AEW-1:0] be_c_reg;
    item_flags_t    fl_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_c_reg <= 1'b0;
        end
        else if (en)
        begin
            v_c_reg <= v_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_c_reg          <= s_sum;
            ae_c_reg         <= ae_b_reg;
            be_c_reg         <= be_b_reg;
            fl_c_reg.applied <= (s_sum != '0) && (!mode_reg || in_range);
            fl_c_reg.neg_x   <= nx_b_reg;
            fl_c_reg.neg_y   <= ny_b_reg;
        end
    end

    // Square root of the squared distance.
    logic               v_q;
    logic [DW-1:0]      root_q;
    logic [SQ_SIDE-1:0] side_q;
    item_flags_t        fl_q;
    logic [AEW-1:0]     ae_q;
    logic [AEW-1:0]     be_q;
    logic [SW-1:0]      s_q;

    prf_isqrt #(
        .SW     (SW),
        .SIDE_W (SQ_SIDE)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_c_reg),
        .value     (s_c_reg),
        .side_in   ({fl_c_reg, ae_c_reg, be_c_reg, s_c_reg}),
        .out_valid (v_q),
        .root      (root_q),
        .side_out  (side_q)
    );

    assign {fl_q, ae_q, be_q, s_q} = side_q;

    // Stage D: remaining distance to the cutoff.
    logic [XW-1:0] rs;
    logic [XW-1:0] ds;
    assign rs = XW'(cutoff_reg) << F;
    assign ds = XW'(root_q) << 8;

    logic           v_d_reg;
    logic [DFW-1:0] diff_d_reg;
    logic [AEW-1:0] ae_d_reg;
    logic [AEW-1:0] be_d_reg;
    logic [SW-1:0]  s_d_reg;
    item_flags_t    fl_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_d_reg <= 1'b0;
        end
        else if (en)
        begin
            v_d_reg <= v_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_d_reg <= (ds < rs) ? DFW'(rs - ds) : '0;
            ae_d_reg   <= ae_q;
            be_d_reg   <= be_q;
            s_d_reg    <= s_q;
            fl_d_reg   <= fl_q;
        end
    end

    // Stage E: partial products, with the strength products and the squared distance split in two halves.
    logic                      v_e_reg;
    logic [H+DFW-1:0]          pxl_e_reg;
    logic [AEW-H+DFW-1:0]      pxh_e_reg;
    logic [H+DFW-1:0]          pyl_e_reg;
    logic [AEW-H+DFW-1:0]      pyh_e_reg;
    logic [SH+CUTOFF_W-1:0]    dl_e_reg;
    logic [SW-SH+CUTOFF_W-1:0] dh_e_reg;
    logic [AEW-1:0]            ae_e_reg;
    logic [AEW-1:0]            be_e_reg;
    logic [SW-1:0]             s_e_reg;
    item_flags_t               fl_e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_e_reg <= 1'b0;
        end
        else if (en)
        begin
            v_e_reg <= v_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxl_e_reg <= (H+DFW)'(ae_d_reg[H-1:0]) * (H+DFW)'(diff_d_reg);
            pxh_e_reg <= (AEW-H+DFW)'(ae_d_reg[AEW-1:H]) * (AEW-H+DFW)'(diff_d_reg);
            pyl_e_reg <= (H+DFW)'(be_d_reg[H-1:0]) * (H+DFW)'(diff_d_reg);
            pyh_e_reg <= (AEW-H+DFW)'(be_d_reg[AEW-1:H]) * (AEW-H+DFW)'(diff_d_reg);
            dl_e_reg  <= (SH+CUTOFF_W)'(s_d_reg[SH-1:0]) * (SH+CUTOFF_W)'(cutoff_reg);
            dh_e_reg  <= (SW-SH+CUTOFF_W)'(s_d_reg[SW-1:SH])
                       * (SW-SH+CUTOFF_W)'(cutoff_reg);
            ae_e_reg  <= ae_d_reg;
            be_e_reg  <= be_d_reg;
            s_e_reg   <= s_d_reg;
            fl_e_reg  <= fl_d_reg;
        end
    end

    // Stage F: numerators and denominator of the selected falloff law.
    logic           v_f_reg;
    logic [NW-1:0]  numx_f_reg;
    logic [NW-1:0]  numy_f_reg;
    logic [DNW-1:0] den_f_reg;
    item_flags_t    fl_f_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_f_reg <= 1'b0;
        end
        else if (en)
        begin
            v_f_reg <= v_e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (mode_reg)
            begin
                numx_f_reg <= ((NW'(pxh_e_reg) << H) + NW'(pxl_e_reg)) << 8;
                numy_f_reg <= ((NW'(pyh_e_reg) << H) + NW'(pyl_e_reg)) << 8;
                den_f_reg  <= (DNW'(dh_e_reg) << SH) + DNW'(dl_e_reg);
            end
            else
            begin
                numx_f_reg <= NW'(ae_e_reg) << (F + 8);
                numy_f_reg <= NW'(be_e_reg) << (F + 8);
                den_f_reg  <= DNW'(s_e_reg);
            end
            fl_f_reg <= fl_e_reg;
        end
    end

    // Division.
    logic               v_v;
    logic [FORCE_W-1:0] qx_v;
    logic [FORCE_W-1:0] qy_v;
    logic               ovfx_v;
    logic               ovfy_v;
    item_flags_t        fl_v;

    prf_divider #(
        .NW  (NW),
        .DNW (DNW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_f_reg),
        .numx      (numx_f_reg),
        .numy      (numy_f_reg),
        .den       (den_f_reg),
        .flags_in  (fl_f_reg),
        .out_valid (v_v),
        .qx        (qx_v),
        .qy        (qy_v),
        .ovfx      (ovfx_v),
        .ovfy      (ovfy_v),
        .flags_out (fl_v)
    );

    // Sign, saturation and the output register.
    localparam logic [FORCE_W-1:0] LIM_POS = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic [FORCE_W-1:0] LIM_NEG = {1'b1, {(FORCE_W-1){1'b0}}};

    logic [FORCE_W-1:0] lim_x;
    logic [FORCE_W-1:0] lim_y;
    logic               sat_x;
    logic               sat_y;
    logic [FORCE_W-1:0] mag_x;
    logic [FORCE_W-1:0] mag_y;
    logic [FORCE_W-1:0] frc_x;
    logic [FORCE_W-1:0] frc_y;

    always_comb
    begin
        lim_x = fl_v.neg_x ? LIM_NEG : LIM_POS;
        lim_y = fl_v.neg_y ? LIM_NEG : LIM_POS;
        sat_x = ovfx_v || (qx_v > lim_x);
        sat_y = ovfy_v || (qy_v > lim_y);
        mag_x = sat_x ? lim_x : qx_v;
        mag_y = sat_y ? lim_y : qy_v;
        frc_x = fl_v.neg_x ? FORCE_W'(-mag_x) : mag_x;
        frc_y = fl_v.neg_y ? FORCE_W'(-mag_y) : mag_y;
    end

    logic                 m_tvalid_reg;
    logic [2*FORCE_W-1:0] m_tdata_reg;
    logic [1:0]           m_tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= v_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (fl_v.applied)
            begin
                m_tdata_reg <= {frc_y, frc_x};
                m_tuser_reg <= {sat_x || sat_y, 1'b1};
            end
            else
            begin
                m_tdata_reg <= '0;
                m_tuser_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/core/prf_checker.sv =====
// Port-level checks on the repulsion force core.
module prf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A pair that did not interact carries no force and no clamp flag.
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata == 64'd0) && !m_tuser[1])
        else $error("non-interacting pair carries a force");

    // A clamp leaves at least one component at a range limit.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |->
            (m_tdata[31:0] == 32'h7FFF_FFFF) || (m_tdata[31:0] == 32'h8000_0000) ||
            (m_tdata[63:32] == 32'h7FFF_FFFF) || (m_tdata[63:32] == 32'h8000_0000))
        else $error("saturated flag without a clamped component");

    // The input side only stalls behind a held result.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled with an open output");

    // A held result stays put until its transfer.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed while stalled");

endmodule

bind pairwise_repulsion_force_core prf_checker u_prf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
